[hdl/epl_pkg.sv]
// Shared types and constants for the encoder PID position loop.
`timescale 1ns / 1ps

package epl_pkg;

  // Operand and result widths of the shared multiplier and accumulator
  localparam int MUL_A_W = 17;  // gains and count deltas, signed
  localparam int MUL_B_W = 34;  // scale, error, derivative, integral, signed
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = MUL_P_W + 2;
  localparam int POS_W   = 32;
  localparam int ERR_W   = 33;
  localparam int INTG_W  = 34;

  // Integral gate (100.0) and clamp (10000.0) in Q16.16
  localparam logic signed [ERR_W-1:0]  INTEG_GATE  = 33'sd6553600;
  localparam logic signed [INTG_W-1:0] INTEG_CLAMP = 34'sd655360000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_WIN = 3'd5;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic [31:0]        dist_scale;
    logic [14:0]        duty_limit;
    logic [30:0]        arrive_window;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] duty;
    logic               arrived;
  } res_t;

endpackage

[hdl/epl_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module epl_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [epl_pkg::MUL_A_W-1:0]    a,
  input  logic signed [epl_pkg::MUL_B_W-1:0]    b,
  output logic signed [epl_pkg::MUL_P_W-1:0]    p_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

[hdl/epl_core.sv]
// Sequencer, per-channel state and datapath around the shared multiplier.
`timescale 1ns / 1ps

module epl_core #(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  epl_pkg::cfg_t       cfg,
  input  logic                start,
  input  logic                in_channel,
  input  logic [15:0]         in_encoder_count,
  input  logic signed [31:0]  in_target,
  input  logic                slot_free,
  output logic                busy,
  output epl_pkg::res_t       res
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW = epl_pkg::ACC_W;
  localparam int PW = epl_pkg::MUL_P_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MPOS, S_POS, S_ERR, S_MKP, S_MKD, S_MKI, S_SUM, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic                              ch_r, ch_nxt;
  logic [15:0]                       cnt_r, cnt_nxt;
  logic signed [31:0]                tgt_r, tgt_nxt;
  logic signed [epl_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic signed [epl_pkg::ERR_W-1:0]  err_r, err_nxt;
  logic signed [epl_pkg::ERR_W-1:0]  der_r, der_nxt;
  logic signed [31:0]                integ_r, integ_nxt;
  logic signed [AW-1:0]              acc_r, acc_nxt;
  logic                              arrived_r, arrived_nxt;

  logic [15:0]        last_count_r    [CHANNELS];
  logic signed [31:0] position_r      [CHANNELS];
  logic signed [31:0] prev_position_r [CHANNELS];
  logic signed [31:0] integral_r      [CHANNELS];

  logic                                 mul_en;
  logic signed [epl_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [epl_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [PW-1:0]                 mul_p;

  logic [IDX_W-1:0] idx;
  logic             res_valid_nxt;
  logic signed [15:0] res_duty_nxt;
  logic             res_arrived_nxt;

  epl_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign idx  = IDX_W'(ch_r);
  assign busy = (state_r != S_IDLE);

  // Operand select for the shared multiplier
  always_comb begin
    logic [15:0] delta;
    delta  = cnt_r - last_count_r[idx];
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_MPOS: begin
        mul_en = 1'b1;
        mul_a  = {delta[15], delta};
        mul_b  = {2'b00, cfg.dist_scale};
      end
      S_MKP: begin
        mul_en = 1'b1;
        mul_a  = {cfg.kp[15], cfg.kp};
        mul_b  = {err_r[32], err_r};
      end
      S_MKD: begin
        mul_en = 1'b1;
        mul_a  = {cfg.kd[15], cfg.kd};
        mul_b  = {der_r[32], der_r};
      end
      S_MKI: begin
        mul_en = 1'b1;
        mul_a  = {cfg.ki[15], cfg.ki};
        mul_b  = {{2{integ_r[31]}}, integ_r};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic signed [PW:0]                  pos_sum;
    logic signed [epl_pkg::INTG_W-1:0]   integ_sum;
    logic [epl_pkg::ERR_W-1:0]           err_abs;
    logic signed [epl_pkg::ERR_W-1:0]    err_v;
    logic signed [AW-1:0]                lim;
    logic signed [AW-1:0]                sat;
    logic signed [AW-1:0]                rnd;

    state_nxt       = state_r;
    ch_nxt          = ch_r;
    cnt_nxt         = cnt_r;
    tgt_nxt         = tgt_r;
    pos_nxt         = pos_r;
    err_nxt         = err_r;
    der_nxt         = der_r;
    integ_nxt       = integ_r;
    acc_nxt         = acc_r;
    arrived_nxt     = arrived_r;
    res_valid_nxt   = 1'b0;
    res_duty_nxt    = res.duty;
    res_arrived_nxt = res.arrived;

    pos_sum   = {{(PW + 1 - epl_pkg::POS_W){position_r[idx][31]}}, position_r[idx]}
                + {mul_p[PW-1], mul_p};
    err_v     = {tgt_r[31], tgt_r} - {pos_r[31], pos_r};
    integ_sum = {{2{integral_r[idx][31]}}, integral_r[idx]};
    if (err_r < epl_pkg::INTEG_GATE) begin
      integ_sum = integ_sum + {err_r[32], err_r};
    end
    err_abs = err_v[32] ? (-err_v) : err_v;
    lim     = {14'd0, cfg.duty_limit, 24'd0};
    if (acc_r > lim) begin
      sat = lim;
    end else if (acc_r < -lim) begin
      sat = -lim;
    end else begin
      sat = acc_r;
    end
    rnd = sat + {{(AW - 24){1'b0}}, 1'b1, 23'd0};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt  = in_channel;
          cnt_nxt = in_encoder_count;
          tgt_nxt = in_target;
          if (32'(in_channel) >= 32'(CHANNELS)) begin
            // No such channel: zero result, state untouched
            acc_nxt     = '0;
            arrived_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_MPOS;
          end
        end
      end
      S_MPOS: state_nxt = S_POS;
      S_POS: begin
        if (pos_sum > (PW + 1)'(33'sh0_7FFF_FFFF)) begin
          pos_nxt = 32'sh7FFF_FFFF;
        end else if (pos_sum < -((PW + 1)'(33'sh0_8000_0000))) begin
          pos_nxt = -32'sh8000_0000;
        end else begin
          pos_nxt = pos_sum[31:0];
        end
        state_nxt = S_ERR;
      end
      S_ERR: begin
        err_nxt     = err_v;
        der_nxt     = {prev_position_r[idx][31], prev_position_r[idx]} - {pos_r[31], pos_r};
        arrived_nxt = err_abs < {2'b00, cfg.arrive_window};
        state_nxt   = S_MKP;
      end
      S_MKP: begin
        if (integ_sum > epl_pkg::INTEG_CLAMP) begin
          integ_nxt = 32'(epl_pkg::INTEG_CLAMP);
        end else if (integ_sum < -epl_pkg::INTEG_CLAMP) begin
          integ_nxt = 32'(-epl_pkg::INTEG_CLAMP);
        end else begin
          integ_nxt = integ_sum[31:0];
        end
        state_nxt = S_MKD;
      end
      S_MKD: begin
        acc_nxt   = {{(AW - PW){mul_p[PW-1]}}, mul_p};
        state_nxt = S_MKI;
      end
      S_MKI: begin
        acc_nxt   = acc_r + {{(AW - PW){mul_p[PW-1]}}, mul_p};
        state_nxt = S_SUM;
      end
      S_SUM: begin
        acc_nxt   = acc_r + {{(AW - PW){mul_p[PW-1]}}, mul_p};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          res_valid_nxt   = 1'b1;
          res_duty_nxt    = arrived_r ? 16'sd0 : rnd[39:24];
          res_arrived_nxt = arrived_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res.valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_count_r[c]    <= '0;
        position_r[c]      <= '0;
        prev_position_r[c] <= '0;
        integral_r[c]      <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      res.valid <= res_valid_nxt;
      if (state_r == S_SUM) begin
        last_count_r[idx]    <= cnt_r;
        position_r[idx]      <= pos_r;
        prev_position_r[idx] <= pos_r;
        integral_r[idx]      <= arrived_r ? 32'sd0 : integ_r;
      end
    end
    ch_r        <= ch_nxt;
    cnt_r       <= cnt_nxt;
    tgt_r       <= tgt_nxt;
    pos_r       <= pos_nxt;
    err_r       <= err_nxt;
    der_r       <= der_nxt;
    integ_r     <= integ_nxt;
    acc_r       <= acc_nxt;
    arrived_r   <= arrived_nxt;
    res.duty    <= res_duty_nxt;
    res.arrived <= res_arrived_nxt;
  end

endmodule

[hdl/encoder_pid_position_loop.sv]
// Top level: PID position loop over quadrature encoder counts.
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_wr_en          cfg_index, cfg_wdata
//   in       in         in_valid/in_stall  in_channel, in_encoder_count, in_target
//   out      out        out_valid/out_stall out_duty, out_arrived
//
// An in-range item keeps the block busy from S_MPOS through S_DONE; a new item is
// taken only once it is back in S_IDLE. The busy span is set by the one shared multiplier,
// which forms count delta*scale, kp*error, kd*derivative and ki*integral in turn.
// An item for a missing channel goes from S_IDLE straight to S_DONE.
// rst_n is synchronous: it clears the channel state and out_valid and sets the config to its defaults.
// A result waits in the output register under out_stall; the next item is
// still taken, and it holds in its last step until the register frees.
`timescale 1ns / 1ps

module encoder_pid_position_loop #(
  parameter int CHANNELS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [epl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [31:0]                           cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_channel,
  input  logic [15:0]                           in_encoder_count,
  input  logic signed [31:0]                    in_target,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    out_duty,
  output logic                                  out_arrived
);

  epl_pkg::cfg_t cfg_r;
  epl_pkg::res_t res;
  logic          busy;
  logic          start;
  logic          slot_free;
  logic          out_valid_r;
  logic signed [15:0] out_duty_r;
  logic          out_arrived_r;

  assign start     = in_valid & ~busy;
  assign in_stall  = busy;
  assign slot_free = ~out_valid_r | ~out_stall;

  // Config registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp            <= '0;
      cfg_r.ki            <= '0;
      cfg_r.kd            <= '0;
      cfg_r.dist_scale    <= 32'd65536;
      cfg_r.duty_limit    <= 15'd32767;
      cfg_r.arrive_window <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        epl_pkg::CFG_KP:         cfg_r.kp            <= cfg_wdata[15:0];
        epl_pkg::CFG_KI:         cfg_r.ki            <= cfg_wdata[15:0];
        epl_pkg::CFG_KD:         cfg_r.kd            <= cfg_wdata[15:0];
        epl_pkg::CFG_DIST_SCALE: cfg_r.dist_scale    <= cfg_wdata;
        epl_pkg::CFG_DUTY_LIMIT: cfg_r.duty_limit    <= cfg_wdata[14:0];
        epl_pkg::CFG_ARRIVE_WIN: cfg_r.arrive_window <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  epl_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .start            (start),
    .in_channel       (in_channel),
    .in_encoder_count (in_encoder_count),
    .in_target        (in_target),
    .slot_free        (slot_free),
    .busy             (busy),
    .res              (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid) begin
      out_duty_r    <= res.duty;
      out_arrived_r <= res.arrived;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty    = out_duty_r;
  assign out_arrived = out_arrived_r;

endmodule

[hdl/epl_check.sv]
// Port-level checks for the encoder PID position loop, bound to the top.
`timescale 1ns / 1ps

module epl_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_duty,
  input logic               out_arrived
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty) && $stable(out_arrived))
    else $error("stalled result changed");

  // Taking an item makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after item taken");

  // Arrival forces zero duty
  a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_duty == 16'sd0)
    else $error("nonzero duty on arrival");

  // A new result only comes out of a busy step; the core result register
  // sits between the last busy cycle and the output register
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall, 2))
    else $error("result without work");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind encoder_pid_position_loop epl_check u_epl_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_duty    (out_duty),
  .out_arrived (out_arrived)
);
